### rtl/core/tpc_pkg.sv
// shared types, constants and table functions of the timer prescaler calculator
package tpc_pkg;

  localparam int unsigned DataWidth = 32;

  localparam logic [DataWidth-1:0] ClockReset = 32'd16000000;
  localparam logic [DataWidth-1:0] Limit8     = 32'd255;
  localparam logic [DataWidth-1:0] Limit16    = 32'd65535;

  // result status codes
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusBad   = 2'd1;
  localparam logic [1:0] StatusNoFit = 2'd2;

  // counter numbers
  localparam logic [1:0] TimerLong  = 2'd1;
  localparam logic [1:0] TimerExtra = 2'd2;
  localparam logic [1:0] TimerNone  = 2'd3;

  // last table index for each table
  localparam logic [2:0] ShortLast = 3'd4;
  localparam logic [2:0] LongLast  = 3'd6;

  typedef struct packed {
    logic [1:0]  timer_index;
    logic [31:0] freq;
    logic        meter_mode;
  } tpc_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  prescaler_index;
    logic [15:0] compare_value;
    logic [31:0] real_freq;
    logic        overflow_mode;
  } tpc_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       next_k;
    logic       save_q;
    logic       wr_res;
    logic [1:0] res_status;
  } tpc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bad;
    logic div_done;
    logic div_busy;
    logic fits;
    logic last_k;
  } tpc_sts_t;

  // prescaler as a left shift: table {1,8,64,256,1024}
  function automatic logic [3:0] short_shift(input logic [2:0] k);
    logic [3:0] s;
    unique case (k)
      3'd0: s = 4'd0;
      3'd1: s = 4'd3;
      3'd2: s = 4'd6;
      3'd3: s = 4'd8;
      3'd4: s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // prescaler as a left shift: table {1,8,32,64,128,256,1024}
  function automatic logic [3:0] long_shift(input logic [2:0] k);
    logic [3:0] s;
    unique case (k)
      3'd0: s = 4'd0;
      3'd1: s = 4'd3;
      3'd2: s = 4'd5;
      3'd3: s = 4'd6;
      3'd4: s = 4'd7;
      3'd5: s = 4'd8;
      3'd6: s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/tpc_chan_if.sv
// valid/ready channel carrying one payload per request
interface tpc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/tpc_divider.sv
// restoring serial divider, one quotient bit per cycle, divide by zero gives all ones
module tpc_divider
  import tpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DataWidth-1:0] num,
  input  logic [DataWidth-1:0] den,
  output logic [DataWidth-1:0] quo,
  output logic                 busy,
  output logic                 done
);

  localparam int unsigned CntWidth = $clog2(DataWidth);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(DataWidth - 1);

  logic [DataWidth-1:0] rem;
  logic [DataWidth-1:0] dsr;
  logic [CntWidth-1:0]  cnt;
  logic [DataWidth:0]   trial;
  logic                 take;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[DataWidth-1]};
    take  = trial >= {1'b0, dsr};
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntLast) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      if (take) begin
        rem <= DataWidth'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DataWidth-1:0];
      end
      quo <= {quo[DataWidth-2:0], take};
    end
  end

endmodule

### rtl/core/tpc_datapath.sv
// operand registers, prescaler walk, divider and result register
module tpc_datapath
  import tpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [DataWidth-1:0] cfg_data,
  input  tpc_req_t             req_data,
  input  tpc_cmd_t             cmd,
  output tpc_sts_t             sts,
  output tpc_rsp_t             rsp_data
);

  logic [DataWidth-1:0] clock_hz;
  tpc_req_t             op;
  logic [2:0]           k;
  logic [16:0]          qsel;
  logic                 phase_real;

  logic [3:0]           sh;
  logic [DataWidth-1:0] den;
  logic [DataWidth-1:0] quo;
  logic [DataWidth-1:0] qm1;
  logic [DataWidth-1:0] limit;
  logic [15:0]          v16;
  logic                 div_busy;
  logic                 div_done;
  logic                 bad;

  // clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= ClockReset;
    end else if (cfg_valid) begin
      clock_hz <= cfg_data;
    end
  end

  // request capture and walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= req_data;
      k          <= '0;
      phase_real <= 1'b0;
    end else begin
      if (cmd.next_k) begin
        k <= k + 1'b1;
      end
      if (cmd.save_q) begin
        qsel       <= quo[16:0];
        phase_real <= 1'b1;
      end
    end
  end

  // divisor: prescaler and factor two are both shifts
  always_comb begin
    if (op.timer_index == TimerExtra) begin
      sh = long_shift(k);
    end else begin
      sh = short_shift(k);
    end
    sh = sh + {3'b0, ~op.meter_mode};
    if (phase_real) begin
      den = {15'b0, qsel} << sh;
    end else begin
      den = op.freq << sh;
    end
  end

  tpc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (clock_hz),
    .den   (den),
    .quo   (quo),
    .busy  (div_busy),
    .done  (div_done)
  );

  // argument check and fit test
  always_comb begin
    qm1   = quo - 1'b1;
    limit = (op.timer_index == TimerLong) ? Limit16 : Limit8;
    if (op.meter_mode) begin
      bad = (op.timer_index != TimerLong) || (op.freq > clock_hz);
    end else begin
      bad = (op.timer_index == TimerNone) || (op.freq > (clock_hz >> 1));
    end
    sts.bad      = bad || (op.freq == '0);
    sts.div_done = div_done;
    sts.div_busy = div_busy;
    sts.fits     = (quo == 32'd1) ||
                   (!op.meter_mode && (quo != '0) && (qm1 <= limit));
    sts.last_k   = (op.timer_index == TimerExtra) ? (k == LongLast) : (k == ShortLast);
    v16          = 16'(qsel - 17'd1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.wr_res) begin
      rsp_data.status <= cmd.res_status;
      if (cmd.res_status == StatusOk) begin
        rsp_data.prescaler_index <= k;
        rsp_data.compare_value   <= op.meter_mode ? 16'd0 : v16;
        rsp_data.real_freq       <= quo;
        rsp_data.overflow_mode   <= !op.meter_mode && (v16 == 16'd0);
      end else begin
        rsp_data.prescaler_index <= '0;
        rsp_data.compare_value   <= '0;
        rsp_data.real_freq       <= '0;
        rsp_data.overflow_mode   <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/tpc_ctrl.sv
// sequencer for the argument check, prescaler walk and final division
module tpc_ctrl
  import tpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  tpc_sts_t sts,
  output tpc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_START,
    S_WAIT,
    S_RSTART,
    S_RWAIT,
    S_RESULT
  } state_t;

  state_t     state;
  logic [1:0] status;
  logic       slot_free;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // commands decoded from state
  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && req_valid;
    cmd.div_start  = (state == S_START) || (state == S_RSTART);
    cmd.next_k     = (state == S_WAIT) && sts.div_done && !sts.fits && !sts.last_k;
    cmd.save_q     = (state == S_WAIT) && sts.div_done && sts.fits;
    cmd.wr_res     = (state == S_RESULT) && slot_free;
    cmd.res_status = status;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status    <= StatusOk;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.wr_res) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts.bad) begin
            status <= StatusBad;
            state  <= S_RESULT;
          end else begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (sts.div_done) begin
            if (sts.fits) begin
              state <= S_RSTART;
            end else if (sts.last_k) begin
              status <= StatusNoFit;
              state  <= S_RESULT;
            end else begin
              state <= S_START;
            end
          end
        end
        S_RSTART: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (sts.div_done) begin
            status <= StatusOk;
            state  <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/timer_prescaler_compare_calc.sv
// top level of the timer prescaler and compare value calculator
// One request (counter number, frequency, mode) gives one result. The block
// checks the arguments, then walks the prescaler table with a shared serial
// divider that for each division starts, forms 32 quotient bits and is
// checked, and ends with one more division for the achieved frequency when an
// entry fits. A request with bad arguments goes straight to the result; any
// other takes one division per prescaler tried, plus the final division on a
// fit. A new request is taken once the previous one has moved to the result
// register, which holds it until it is taken. The clock register resets to
// 16 MHz and is written through its own channel.
module timer_prescaler_compare_calc
  import tpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  tpc_chan_if.sink   cfg,
  tpc_chan_if.sink   req,
  tpc_chan_if.source rsp
);

  tpc_cmd_t cmd;
  tpc_sts_t sts;
  tpc_rsp_t rsp_data;
  tpc_req_t req_data;
  logic     req_ready;
  logic     rsp_valid;

  assign cfg.ready = 1'b1;
  assign req_data  = req.data;
  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  tpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_data  (rsp_data)
  );

  // divider is idle whenever a division is started or a request comes in
  assert property (@(posedge clk) disable iff (rst)
    (cmd.div_start || cmd.load) |-> !sts.div_busy)
    else $error("divider restarted while busy");

  // failed results carry zero fields
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.status != StatusOk)) |->
      (rsp_data.prescaler_index == 3'd0 && rsp_data.compare_value == 16'd0 &&
       rsp_data.real_freq == 32'd0 && !rsp_data.overflow_mode))
    else $error("failed result with nonzero fields");

  // overflow mode only with a zero compare value on success
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.overflow_mode) |->
      (rsp_data.status == StatusOk && rsp_data.compare_value == 16'd0))
    else $error("overflow mode with nonzero compare value");

  // result register is written only into a free slot
  assert property (@(posedge clk) disable iff (rst)
    cmd.wr_res |-> (!rsp_valid || rsp.ready))
    else $error("result overwritten before it was taken");

endmodule

### bench/timer_prescaler_compare_calc_checker.sv
// checker of the timer prescaler calculator: predicts each result and compares it
module timer_prescaler_compare_calc_checker
  import tpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tpc_chan_if  cfg,
  tpc_chan_if  req,
  tpc_chan_if  rsp,
  output int   failures,
  output int   outstanding,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] clock_copy;
  tpc_rsp_t    expected_settings[$];

  // prescaler of table entry k for the given counter
  function automatic logic [31:0] prescale_of(input logic [1:0] timer, input int k);
    logic [31:0] p;
    if (timer == TimerExtra) begin
      case (k)
        0: p = 32'd1;
        1: p = 32'd8;
        2: p = 32'd32;
        3: p = 32'd64;
        4: p = 32'd128;
        5: p = 32'd256;
        default: p = 32'd1024;
      endcase
    end else begin
      case (k)
        0: p = 32'd1;
        1: p = 32'd8;
        2: p = 32'd64;
        3: p = 32'd256;
        default: p = 32'd1024;
      endcase
    end
    return p;
  endfunction

  // 32-bit quotient, all ones when the divisor wrapped to zero
  function automatic logic [31:0] wrap_div(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] q;
    if (den == 32'd0) q = 32'hFFFF_FFFF;
    else q = num / den;
    return q;
  endfunction

  // prescaler and compare value chosen for one request
  function automatic tpc_rsp_t predict_setting(input tpc_req_t r, input logic [31:0] clk_hz);
    tpc_rsp_t    res;
    logic        bad;
    logic [31:0] limit;
    logic [31:0] factor;
    logic [31:0] divisor;
    logic [31:0] v;
    logic [31:0] achieved;
    int          count;
    int          chosen;
    res = '0;
    if (r.meter_mode) bad = (r.timer_index != TimerLong) || (r.freq > clk_hz);
    else bad = (r.timer_index == TimerNone) || (r.freq > clk_hz / 32'd2);
    if (r.freq == 32'd0 || bad) begin
      res.status = StatusBad;
      return res;
    end
    count  = (r.timer_index == TimerExtra) ? 7 : 5;
    limit  = (r.timer_index == TimerLong) ? Limit16 : Limit8;
    factor = r.meter_mode ? 32'd1 : 32'd2;
    chosen = -1;
    v = 32'd0;
    // walk the table, stop at the first fitting entry
    for (int k = 0; k < count && chosen < 0; k++) begin
      divisor = factor * r.freq * prescale_of(r.timer_index, k);
      v = wrap_div(clk_hz, divisor) - 32'd1;
      if (v == 32'd0 || (!r.meter_mode && v <= limit)) chosen = k;
    end
    if (chosen < 0) begin
      res.status = StatusNoFit;
      return res;
    end
    divisor  = factor * prescale_of(r.timer_index, chosen) * (v + 32'd1);
    achieved = wrap_div(clk_hz, divisor);
    res.status          = StatusOk;
    res.prescaler_index = 3'(chosen);
    res.compare_value   = r.meter_mode ? 16'd0 : v[15:0];
    res.real_freq       = achieved;
    res.overflow_mode   = !r.meter_mode && (v == 32'd0);
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
    end
  endtask

  initial begin
    failures    = 0;
    outstanding = 0;
    checked     = 0;
  end

  // watch the channels at each rising edge
  always @(posedge clk) begin : watch
    tpc_rsp_t want;
    if (rst) begin
      clock_copy = ClockReset;
      expected_settings.delete();
    end else begin
      if (cfg.valid && cfg.ready) clock_copy = cfg.data;
      // compare a taken result with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (expected_settings.size() == 0) begin
          failures++;
          $display("%0t ns: result with nothing expected, expected none actual 0x%0h",
                   $time, rsp.data);
        end else begin
          want = expected_settings.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.data.status));
          check_field("prescaler_index", 32'(want.prescaler_index),
                      32'(rsp.data.prescaler_index));
          check_field("compare_value", 32'(want.compare_value), 32'(rsp.data.compare_value));
          check_field("real_freq", want.real_freq, rsp.data.real_freq);
          check_field("overflow_mode", 32'(want.overflow_mode), 32'(rsp.data.overflow_mode));
          checked++;
        end
      end
      // predict every accepted request
      if (req.valid && req.ready)
        expected_settings.push_back(predict_setting(req.data, clock_copy));
    end
    outstanding = expected_settings.size();
  end

endmodule

### bench/timer_prescaler_compare_calc_test.sv
// top of the timer prescaler calculator bench: clock, reset, stimulus and verdict
module timer_prescaler_compare_calc_test;
  import tpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // keep a wide margin over the slowest run
  localparam int CycleLimit  = 2_500_000;
  localparam int PhaseCount  = 14;
  localparam int HoldCycles  = 500;
  localparam int DrainCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int          failures;
  int          outstanding;
  int          checked;
  int          idle_max = 13;
  bit          hold_off_pending = 1'b0;
  int          requests_sent = 0;
  int          cycle_count = 0;
  logic [31:0] clock_now = ClockReset;

  tpc_chan_if #(.payload_t(logic [31:0])) cfg_if ();
  tpc_chan_if #(.payload_t(tpc_req_t))    req_if ();
  tpc_chan_if #(.payload_t(tpc_rsp_t))    rsp_if ();

  timer_prescaler_compare_calc dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .req (req_if),
    .rsp (rsp_if)
  );

  timer_prescaler_compare_calc_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_if),
    .req         (req_if),
    .rsp         (rsp_if),
    .failures    (failures),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timer_prescaler_compare_calc: mismatch");
      $finish;
    end
  end

  function automatic tpc_req_t make_request(input logic [1:0] timer, input logic [31:0] freq,
                                            input logic meter);
    tpc_req_t item;
    item.timer_index = timer;
    item.freq        = freq;
    item.meter_mode  = meter;
    return item;
  endfunction

  // mostly frequencies that land on a table entry, some noise
  function automatic tpc_req_t random_request(input logic [31:0] clk_hz);
    tpc_req_t        item;
    int              sel;
    int              k;
    longint unsigned p;
    longint unsigned v;
    longint unsigned lim;
    longint unsigned base;
    longint unsigned f;
    item = '0;
    sel = $urandom_range(0, 9);
    if (sel <= 4) begin
      // compare mode aimed at a chosen entry and compare value
      item.timer_index = 2'($urandom_range(0, 2));
      if (item.timer_index == TimerExtra) begin
        k = $urandom_range(0, 6);
        p = 64'd1 << long_shift(3'(k));
      end else begin
        k = $urandom_range(0, 4);
        p = 64'd1 << short_shift(3'(k));
      end
      lim = (item.timer_index == TimerLong) ? 64'd65535 : 64'd255;
      v = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3))
                                      : 64'($urandom_range(0, 32'(lim)));
      base = 64'(clk_hz) / (64'd2 * p * (v + 64'd1));
      f = base + 64'($urandom_range(0, 2));
      f = (f > 64'd1) ? f - 64'd1 : 64'd1;
    end else if (sel <= 6) begin
      // meter mode near the point where the quotient is one
      item.timer_index = TimerLong;
      item.meter_mode  = 1'b1;
      k = $urandom_range(0, 4);
      p = 64'd1 << short_shift(3'(k));
      base = 64'(clk_hz) / p;
      if ($urandom_range(0, 3) == 0) base = base / 64'd2 + 64'd1;
      f = (base > 64'd2) ? base - 64'($urandom_range(0, 2)) : 64'd1;
    end else if (sel == 7) begin
      item.timer_index = 2'($urandom_range(0, 3));
      item.meter_mode  = 1'($urandom_range(0, 1));
      f = 64'($urandom >> $urandom_range(0, 31));
    end else if (sel == 8) begin
      item.timer_index = 2'($urandom_range(0, 3));
      item.meter_mode  = 1'($urandom_range(0, 1));
      f = 64'($urandom);
    end else begin
      item.timer_index = 2'($urandom_range(0, 2));
      item.meter_mode  = 1'($urandom_range(0, 1));
      f = 64'($urandom_range(1, 1000));
    end
    item.freq = f[31:0];
    return item;
  endfunction

  function automatic logic [31:0] clock_for_phase(input int phase);
    logic [31:0] c;
    case (phase)
      0: c = 32'd1;
      1: c = 32'hFFFF_FFFF;
      2: c = ClockReset;
      3: c = 32'd2;
      4: c = 32'd1000000;
      5: c = 32'd20000000;
      6: c = 32'd8000000;
      7: c = $urandom | 32'd1;
      8: c = $urandom_range(32768, 100000);
      default: c = $urandom_range(100000, 50000000);
    endcase
    return c;
  endfunction

  // offer one request after a random gap; valid stays high until the next call
  task automatic offer_request(input tpc_req_t item);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
  endtask

  task automatic wait_results();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_clock(input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    clock_now = value;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int pause;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        pause = HoldCycles;
      end else begin
        pause = $urandom_range(0, idle_max);
      end
      if (pause > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  // stimulus
  initial begin
    int items;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset clock of 16 MHz
    offer_request(make_request(2'd0, 32'd0, 1'b0));          // zero frequency
    offer_request(make_request(TimerNone, 32'd1000, 1'b0));  // no such counter
    offer_request(make_request(TimerNone, 32'd1000, 1'b1));
    offer_request(make_request(2'd0, 32'd1000, 1'b1));       // meter on an 8-bit counter
    offer_request(make_request(TimerExtra, 32'd1000, 1'b1));
    offer_request(make_request(2'd0, 32'd8000000, 1'b0));    // half clock, overflow mode
    offer_request(make_request(2'd0, 32'd8000001, 1'b0));    // just above half clock
    offer_request(make_request(TimerLong, 32'd16000000, 1'b1));
    offer_request(make_request(TimerLong, 32'd16000001, 1'b1));
    offer_request(make_request(2'd0, 32'hFFFF_FFFF, 1'b0));
    offer_request(make_request(2'd0, 32'd1, 1'b0));          // no prescaler fits
    offer_request(make_request(TimerLong, 32'd1, 1'b0));     // fits on the 256 prescaler entry
    offer_request(make_request(TimerExtra, 32'd1, 1'b0));
    offer_request(make_request(TimerExtra, 32'd31250, 1'b0)); // value exactly 255
    offer_request(make_request(2'd0, 32'd31128, 1'b0));      // 256 on the first entry
    offer_request(make_request(TimerLong, 32'd3, 1'b1));     // meter finds nothing
    offer_request(make_request(TimerLong, 32'd15625, 1'b1)); // meter on the last entry
    offer_request(make_request(TimerLong, 32'd122, 1'b0));   // just past the 16-bit limit
    req_if.valid <= 1'b0;
    wait_results();

    // directed part at the top clock: wrapped divisors and boundaries
    write_clock(32'hFFFF_FFFF);
    offer_request(make_request(TimerLong, 32'h4000_0000, 1'b1));
    offer_request(make_request(2'd0, 32'h7FFF_FFFF, 1'b0));
    offer_request(make_request(2'd0, 32'h8000_0000, 1'b0));
    offer_request(make_request(TimerLong, 32'hFFFF_FFFF, 1'b1));
    offer_request(make_request(TimerExtra, 32'h0040_0000, 1'b0));
    req_if.valid <= 1'b0;
    wait_results();

    // random phases, each at its own clock setting
    for (int phase = 0; phase < PhaseCount; phase++) begin
      write_clock(clock_for_phase(phase));
      idle_max = (phase == 4 || phase == 9) ? 0 : 13;
      items = (phase == 0 || phase == 3) ? 40 : 105;
      for (int i = 0; i < items; i++) begin
        if (phase == 2 && i == 20) hold_off_pending = 1'b1;
        if (phase == 5 && i == 50) begin
          // sender pause until every result is back
          req_if.valid <= 1'b0;
          wait_results();
        end
        offer_request(random_request(clock_now));
      end
      req_if.valid <= 1'b0;
      wait_results();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d requests over %0d clock settings, %0d results compared",
             requests_sent, PhaseCount + 2, checked);
    $display("with bad arguments, no fit, overflow, wrapped divisors, a long stall and a drain");
    if (failures == 0) begin
      $display("timer_prescaler_compare_calc: match");
    end else begin
      $display("timer_prescaler_compare_calc: mismatch");
    end
    $finish;
  end

endmodule

### timer_prescaler_compare_calc.f
rtl/core/tpc_pkg.sv
rtl/core/tpc_chan_if.sv
rtl/core/tpc_divider.sv
rtl/core/tpc_datapath.sv
rtl/core/tpc_ctrl.sv
rtl/core/timer_prescaler_compare_calc.sv
bench/timer_prescaler_compare_calc_checker.sv
bench/timer_prescaler_compare_calc_test.sv
